FILE: sv/escaped_utf8_transcoder_macros.svh
// Assertion macros used by the transcoder checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ESCAPED_UTF8_TRANSCODER_MACROS_SVH
`define ESCAPED_UTF8_TRANSCODER_MACROS_SVH

// Checked only while out of reset
`define EUXC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define EUXC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/euxc_pkg.sv
// Shared types and constants for the escaped UTF-8 transcoder.
// No dependencies; used by front, back and top level.
package euxc_pkg;

    // Default depth of the character queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_OUT_CAPACITY = 1'b0;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // Characters with a meaning to the escape logic
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_LF        = 8'h0A;

    // One queue entry: up to two decoded characters, plus end-of-string status
    typedef struct packed {
        logic [1:0]  nchar;
        logic [15:0] char_a;
        logic [15:0] char_b;
        logic        fin;
        logic        err;
    } char_item_t;

endpackage

FILE: sv/euxc_fifo.sv
// Small flop-based queue between the front and back parts.
// No package dependencies; width and depth are parameters.
module euxc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/euxc_front.sv
// Front part: accepts source bytes, decodes UTF-8 and resolves escapes.
// Depends on euxc_pkg; pushes decoded characters into the queue.
module euxc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 is_end,
    output logic                 push,
    output euxc_pkg::char_item_t push_item,
    input  logic                 fifo_full
);
    import euxc_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX
    } esc_mode_t;

    typedef struct packed {
        esc_mode_t   mode;
        logic [2:0]  hex_left;
        logic [15:0] hex_acc;
        logic [1:0]  cont_left;
        logic [20:0] partial;
        logic        err;
    } scan_state_t;

    typedef struct packed {
        scan_state_t st;
        logic        emit;
        logic [15:0] code;
    } char_res_t;

    // Escape handling of one decoded character
    function automatic char_res_t handle_char(scan_state_t st, logic [20:0] c);
        char_res_t r;
        r      = '0;
        r.st   = st;
        r.code = c[15:0];
        if (!st.err)
        begin
            if (st.mode == MODE_ESCAPE)
            begin
                if (c == {13'd0, CHAR_BACKSLASH})
                begin
                    r.st.mode = MODE_NORMAL;
                    r.emit    = 1'b1;
                end
                else if (c == {13'd0, CHAR_N})
                begin
                    r.st.mode = MODE_NORMAL;
                    r.emit    = 1'b1;
                    r.code    = {8'd0, CHAR_LF};
                end
                else if (c == {13'd0, CHAR_X} || c == {13'd0, CHAR_U})
                begin
                    r.st.mode     = MODE_HEX;
                    r.st.hex_left = (c == {13'd0, CHAR_X}) ? 3'd2 : 3'd4;
                    r.st.hex_acc  = '0;
                end
                else
                begin
                    r.st.err = 1'b1;
                end
            end
            else if (c == {13'd0, CHAR_BACKSLASH})
            begin
                r.st.mode = MODE_ESCAPE;
            end
            else if (c[20:16] != '0)
            begin
                // beyond 16 bits: no encoding
                r.st.err = 1'b1;
            end
            else
            begin
                r.emit = 1'b1;
            end
        end
        return r;
    endfunction

    // One raw hex digit while collecting \x or \u
    function automatic char_res_t hex_digit(scan_state_t st, logic [7:0] b);
        char_res_t  r;
        logic [3:0] v;
        logic       ok;
        r  = '0;
        r.st = st;
        ok = 1'b1;
        v  = '0;
        unique case (b) inside
            [8'h30:8'h39]: v = b[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: v = b[3:0] + 4'd9;
            default:       ok = 1'b0;
        endcase
        if (!ok)
        begin
            r.st.err = 1'b1;
        end
        else
        begin
            r.st.hex_acc = {st.hex_acc[11:0], v};
            if (st.hex_left != '0)
            begin
                r.st.hex_left = st.hex_left - 3'd1;
            end
            if (r.st.hex_left == '0)
            begin
                r.st.mode = MODE_NORMAL;
                r.emit    = 1'b1;
                r.code    = r.st.hex_acc;
            end
        end
        r.code = r.st.hex_acc;
        return r;
    endfunction

    scan_state_t st_reg, st_next, s;
    char_res_t   res_a, res_b, res_c, res_d;
    logic        a_emit, b_emit;
    logic [15:0] a_code, b_code;
    logic        accept;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    // Decode one byte: slot A takes a completed or flushed character,
    // slot B the character of this byte or the end-of-string flush
    always_comb
    begin
        s      = st_reg;
        a_emit = 1'b0;
        b_emit = 1'b0;
        a_code = '0;
        b_code = '0;
        res_a  = handle_char(st_reg, st_reg.partial);
        res_b  = '0;
        res_c  = '0;
        res_d  = '0;
        if (!s.err)
        begin
            if (s.cont_left != '0 && in_byte[7:6] == 2'b10)
            begin
                // continuation byte
                s.partial   = {s.partial[14:0], in_byte[5:0]};
                s.cont_left = s.cont_left - 2'd1;
                if (s.cont_left == '0)
                begin
                    res_a  = handle_char(s, s.partial);
                    s      = res_a.st;
                    a_emit = res_a.emit;
                    a_code = res_a.code;
                end
            end
            else
            begin
                // truncated character completes with what it has
                if (s.cont_left != '0)
                begin
                    s.cont_left = '0;
                    res_a  = handle_char(s, s.partial);
                    s      = res_a.st;
                    a_emit = res_a.emit;
                    a_code = res_a.code;
                end
                if (!s.err)
                begin
                    if (s.mode == MODE_HEX)
                    begin
                        res_b  = hex_digit(s, in_byte);
                        s      = res_b.st;
                        b_emit = res_b.emit;
                        b_code = res_b.code;
                    end
                    else if (!in_byte[7])
                    begin
                        res_c  = handle_char(s, {13'd0, in_byte});
                        s      = res_c.st;
                        b_emit = res_c.emit;
                        b_code = res_c.code;
                    end
                    else if (in_byte[7:5] == 3'b110)
                    begin
                        s.partial   = {16'd0, in_byte[4:0]};
                        s.cont_left = 2'd1;
                    end
                    else if (in_byte[7:4] == 4'b1110)
                    begin
                        s.partial   = {17'd0, in_byte[3:0]};
                        s.cont_left = 2'd2;
                    end
                    else
                    begin
                        s.partial   = {18'd0, in_byte[2:0]};
                        s.cont_left = 2'd3;
                    end
                end
            end
        end
        // end of string: flush pending character, check dangling escape
        if (is_end)
        begin
            if (!s.err && s.cont_left != '0)
            begin
                s.cont_left = '0;
                res_d  = handle_char(s, s.partial);
                s      = res_d.st;
                b_emit = res_d.emit;
                b_code = res_d.code;
            end
            if (!s.err && s.mode != MODE_NORMAL)
            begin
                s.err = 1'b1;
            end
        end
        st_next = st_reg;
        if (accept)
        begin
            st_next = is_end ? scan_state_t'('0) : s;
        end
    end

    // Queue entry, characters packed to the front
    always_comb
    begin
        push_item.nchar  = {a_emit & b_emit, a_emit ^ b_emit};
        push_item.char_a = a_emit ? a_code : b_code;
        push_item.char_b = b_code;
        push_item.fin    = is_end;
        push_item.err    = s.err;
        push = accept && (a_emit || b_emit || is_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

FILE: sv/euxc_back.sv
// Back part: encodes queued characters as UTF-8 bytes, one item per cycle while out_ready allows.
// Depends on euxc_pkg; owns the output register and the byte count.
module euxc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  euxc_pkg::char_item_t item,
    input  logic                 item_avail,
    output logic                 pop,
    input  logic [15:0]          capacity,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 byte_kept,
    output logic                 is_final,
    output logic                 error,
    output logic [15:0]          total_count
);
    import euxc_pkg::*;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_FINAL
    } phase_t;

    // Byte bi of the UTF-8 form of code, len bytes long
    function automatic logic [7:0] enc_byte(logic [15:0] code, logic [1:0] len,
                                            logic [1:0] bi);
        logic [7:0] b;
        b = code[7:0];
        if (len == 2'd2)
        begin
            b = (bi == 2'd0) ? {3'b110, code[10:6]} : {2'b10, code[5:0]};
        end
        else if (len == 2'd3)
        begin
            case (bi)
                2'd0:    b = {4'b1110, code[15:12]};
                2'd1:    b = {2'b10, code[11:6]};
                default: b = {2'b10, code[5:0]};
            endcase
        end
        return b;
    endfunction

    char_item_t  ent_reg, ent_next;
    logic        have_reg, have_next;
    phase_t      ph_reg, ph_next;
    logic [1:0]  bi_reg, bi_next;
    logic [15:0] count_reg, count_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        kept_reg, kept_next;
    logic        final_reg, final_next;
    logic        err_reg, err_next;
    logic [15:0] total_reg, total_next;

    logic        advance, entry_done, last_byte, load;
    logic [15:0] cur_code;
    logic [1:0]  cur_len;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_kept   = kept_reg;
    assign is_final    = final_reg;
    assign error       = err_reg;
    assign total_count = total_reg;
    assign pop         = load;

    // Current character and where the walk stands in it
    always_comb
    begin
        cur_code = (ph_reg == PH_B) ? ent_reg.char_b : ent_reg.char_a;
        if (cur_code < 16'h0080)
        begin
            cur_len = 2'd1;
        end
        else if (cur_code < 16'h0800)
        begin
            cur_len = 2'd2;
        end
        else
        begin
            cur_len = 2'd3;
        end
        last_byte  = (bi_reg == cur_len - 2'd1);
        advance    = have_reg && (!out_valid_reg || out_ready);
        entry_done = (ph_reg == PH_FINAL) ||
                     (last_byte && !ent_reg.fin &&
                      (ph_reg == PH_B || ent_reg.nchar != 2'd2));
        load = (!have_reg || (advance && entry_done)) && item_avail;
    end

    // Sequencer and output register
    always_comb
    begin
        ent_next       = ent_reg;
        have_next      = have_reg;
        ph_next        = ph_reg;
        bi_next        = bi_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        kept_next      = kept_reg;
        final_next     = final_reg;
        err_next       = err_reg;
        total_next     = total_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            unique case (ph_reg)
                PH_FINAL:
                begin
                    out_byte_next = '0;
                    kept_next     = 1'b0;
                    final_next    = 1'b1;
                    err_next      = ent_reg.err;
                    total_next    = count_reg;
                    count_next    = '0;
                end
                PH_A, PH_B:
                begin
                    out_byte_next = enc_byte(cur_code, cur_len, bi_reg);
                    kept_next     = (count_reg < capacity);
                    final_next    = 1'b0;
                    err_next      = 1'b0;
                    total_next    = '0;
                    if (count_reg != 16'hFFFF)
                    begin
                        count_next = count_reg + 16'd1;
                    end
                    // step to the next byte, character or status item
                    if (!last_byte)
                    begin
                        bi_next = bi_reg + 2'd1;
                    end
                    else if (ph_reg == PH_A && ent_reg.nchar == 2'd2)
                    begin
                        ph_next = PH_B;
                        bi_next = '0;
                    end
                    else
                    begin
                        ph_next = PH_FINAL;
                    end
                end
                default:
                begin
                    out_valid_next = out_valid_reg;
                end
            endcase
            if (entry_done)
            begin
                have_next = 1'b0;
            end
        end

        if (load)
        begin
            ent_next  = item;
            have_next = 1'b1;
            ph_next   = (item.nchar != '0) ? PH_A : PH_FINAL;
            bi_next   = '0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg       <= '0;
            have_reg      <= 1'b0;
            ph_reg        <= PH_A;
            bi_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            kept_reg      <= 1'b0;
            final_reg     <= 1'b0;
            err_reg       <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            ent_reg       <= ent_next;
            have_reg      <= have_next;
            ph_reg        <= ph_next;
            bi_reg        <= bi_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            kept_reg      <= kept_next;
            final_reg     <= final_next;
            err_reg       <= err_next;
            total_reg     <= total_next;
        end
    end

endmodule

FILE: sv/escaped_utf8_transcoder.sv
// An accepted byte's results pass through the queue, the entry register of the
// back part and the output register. One result item per cycle while out_ready
// allows; a byte yields 0 to 6 UTF-8 bytes plus a status item at string end.
// The one-byte-per-cycle output register sets the rate; a queue of
// QUEUE_DEPTH entries lets input run ahead. Reset clears all string state,
// the queue and the output valid at once; out_capacity resets to 65535.
module escaped_utf8_transcoder #(
    parameter int QUEUE_DEPTH = euxc_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [euxc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [euxc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [euxc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // source bytes
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            is_end,
    // result items
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            byte_kept,
    output logic                            is_final,
    output logic                            error,
    output logic [15:0]                     total_count
);
    import euxc_pkg::*;

    localparam int ITEM_W = $bits(char_item_t);

    logic [15:0] capacity_reg, capacity_next;
    logic        reg_sel, cfg_write;
    logic        push, pop, fifo_full, fifo_empty;
    char_item_t  push_item, pop_item;

    // Register decode, word addressed
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_ADDR_W-1] == REG_IDX_OUT_CAPACITY);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? {{(APB_DATA_W-16){1'b0}}, capacity_reg} : '0;

    always_comb
    begin
        capacity_next = cfg_write ? pwdata[15:0] : capacity_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    euxc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .is_end    (is_end),
        .push      (push),
        .push_item (push_item),
        .fifo_full (fifo_full)
    );

    euxc_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_item),
        .empty     (fifo_empty)
    );

    euxc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (pop_item),
        .item_avail  (!fifo_empty),
        .pop         (pop),
        .capacity    (capacity_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_kept   (byte_kept),
        .is_final    (is_final),
        .error       (error),
        .total_count (total_count)
    );

endmodule

FILE: sv/euxc_check.sv
// Port-level checker for the transcoder, bound to the top level.
// Depends on euxc_pkg and escaped_utf8_transcoder_macros.svh.
`include "escaped_utf8_transcoder_macros.svh"

module euxc_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [euxc_pkg::APB_ADDR_W-1:0] paddr,
    input logic [euxc_pkg::APB_DATA_W-1:0] pwdata,
    input logic [euxc_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [7:0]                      in_byte,
    input logic                            is_end,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [7:0]                      out_byte,
    input logic                            byte_kept,
    input logic                            is_final,
    input logic                            error,
    input logic [15:0]                     total_count
);
    // No result item is shown once a reset edge has been seen
    `EUXC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "out_valid high in reset")

    // A stalled result item holds
    `EUXC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_final) && $stable(total_count), "stalled item changed")

    // Byte items carry no status
    `EUXC_ASSERT(a_byte_clean, out_valid && !is_final |-> !error && total_count == 16'd0, "status on byte item")

    // Status items carry no byte
    `EUXC_ASSERT(a_final_clean, out_valid && is_final |-> out_byte == 8'd0 && !byte_kept, "byte on status item")

endmodule

bind escaped_utf8_transcoder euxc_check u_check (.*);
